>>> src/ttbc_pkg.sv
// Shared types, constants and codes for the tap tempo beat clock.
package ttbc_pkg;

  localparam int TAP_DEPTH = 8;
  localparam int FILL_W    = $clog2(TAP_DEPTH + 1);
  localparam int N_W       = $clog2(TAP_DEPTH);
  localparam int SUM_W     = 32 + $clog2(TAP_DEPTH);
  localparam int DIV_W     = SUM_W;
  localparam int DCNT_W    = $clog2(DIV_W);

  localparam logic [31:0] STALE_US      = 32'd4000000;
  localparam logic [31:0] US_PER_MIN    = 32'd60000000;
  localparam logic [31:0] TEMPO_NUM_Q4  = 32'd960000;
  localparam logic [9:0]  US_PER_MS     = 10'd1000;
  localparam logic [7:0]  RST_MIN_TEMPO = 8'd30;
  localparam logic [2:0]  RST_MIN_INTV  = 3'd2;

  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_TAP    = 2'd1;
  localparam logic [1:0] MODE_SET    = 2'd2;

  localparam logic REG_MIN_TEMPO = 1'b0;
  localparam logic REG_MIN_INTV  = 1'b1;

  localparam logic [1:0] SYM_OFF  = 2'd0;
  localparam logic [1:0] SYM_UP   = 2'd1;
  localparam logic [1:0] SYM_DOWN = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] time_us;
    logic [6:0]  cc_value;
  } ttbc_in_t;

  typedef struct packed {
    logic [1:0]  beat_symbol;
    logic        beat_event;
    logic [11:0] tempo_rounded;
    logic [31:0] beat_interval_us;
    logic [3:0]  taps_held;
    logic [7:0]  controller_readback;
  } ttbc_out_t;

  typedef struct packed {
    logic purge;
    logic push;
    logic sum_start;
  } ttbc_tap_ctl_t;

  typedef struct packed {
    logic              sum_done;
    logic [FILL_W-1:0] fill;
  } ttbc_tap_sts_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ttbc_div_sts_t;

endpackage

>>> src/ttbc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module ttbc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ttbc_pkg::DIV_W-1:0] dividend,
  input  logic [ttbc_pkg::DIV_W-1:0] divisor,
  output logic [ttbc_pkg::DIV_W-1:0] quotient,
  output ttbc_pkg::ttbc_div_sts_t    sts
);
  import ttbc_pkg::*;

  logic [DIV_W:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    shifted;

  // Trial subtract of one shifted-in dividend bit
  always_comb begin
    shifted = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    if (!trial[DIV_W]) begin
      rem_nxt = trial;
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == DCNT_W'(DIV_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Shift datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

>>> src/ttbc_taps.sv
// Tap stamp window with stale purge and a rotating interval summer.
module ttbc_taps (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ttbc_pkg::ttbc_tap_ctl_t    ctl,
  input  logic [31:0]                now,
  output logic [ttbc_pkg::SUM_W-1:0] sum,
  output ttbc_pkg::ttbc_tap_sts_t    sts
);
  import ttbc_pkg::*;

  logic [31:0]       stamp_r [TAP_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [SUM_W-1:0]  sum_r;
  logic [N_W-1:0]    rot_cnt_r;
  logic              rot_r, done_r;
  logic              stale;
  logic              full;
  logic [N_W-1:0]    n_int;
  logic [31:0]       diff;

  assign stale = (fill_r != '0) && ((now - stamp_r[0]) >= STALE_US);
  assign full  = (fill_r == FILL_W'(TAP_DEPTH));
  assign n_int = N_W'(fill_r - 1'b1);
  assign diff  = stamp_r[1] - stamp_r[0];

  // Stamp storage: drop, append, rotate
  always_ff @(posedge clk) begin
    if (ctl.purge && stale) begin
      for (int k = 0; k < TAP_DEPTH - 1; k++) stamp_r[k] <= stamp_r[k + 1];
    end else if (ctl.push) begin
      if (full) begin
        for (int k = 0; k < TAP_DEPTH - 1; k++) stamp_r[k] <= stamp_r[k + 1];
        stamp_r[TAP_DEPTH - 1] <= now;
      end else begin
        stamp_r[N_W'(fill_r)] <= now;
      end
    end else if (rot_r) begin
      for (int k = 0; k < TAP_DEPTH - 1; k++) stamp_r[k] <= stamp_r[k + 1];
      stamp_r[TAP_DEPTH - 1] <= stamp_r[0];
    end
  end

  // Fill count and summing sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      rot_r     <= 1'b0;
      done_r    <= 1'b0;
      rot_cnt_r <= '0;
    end else begin
      done_r <= rot_r && !ctl.sum_start && (rot_cnt_r == N_W'(TAP_DEPTH - 1));
      if (ctl.purge && stale) begin
        fill_r <= fill_r - 1'b1;
      end else if (ctl.push && !full) begin
        fill_r <= fill_r + 1'b1;
      end
      if (ctl.sum_start) begin
        rot_r     <= 1'b1;
        rot_cnt_r <= '0;
      end else if (rot_r) begin
        rot_cnt_r <= rot_cnt_r + 1'b1;
        if (rot_cnt_r == N_W'(TAP_DEPTH - 1)) begin
          rot_r <= 1'b0;
        end
      end
    end
  end

  // Accumulate one interval per rotation step
  always_ff @(posedge clk) begin
    if (ctl.sum_start) begin
      sum_r <= '0;
    end else if (rot_r && (rot_cnt_r < n_int)) begin
      sum_r <= sum_r + SUM_W'(diff);
    end
  end

  assign sum          = sum_r;
  assign sts.fill     = fill_r;
  assign sts.sum_done = done_r;

endmodule

>>> src/tap_tempo_beat_clock.sv
// Throughput: one item at a time, through the bit-serial divider (DIV_W = 35 at a depth
// of 8) and the window rotation. A new item is taken while the last result waits.
// Reset (rst_n, synchronous): registers at 30 and 2, tempo 30 bpm, no taps,
// interval, beat time and phase zero. No clearing pass.
module tap_tempo_beat_clock (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ttbc_pkg::ttbc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ttbc_pkg::ttbc_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ttbc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_STEP   = 9'b000000010,
    S_PUSH   = 9'b000000100,
    S_SUM    = 9'b000001000,
    S_CHK    = 9'b000010000,
    S_DIV1   = 9'b000100000,
    S_DIV2   = 9'b001000000,
    S_SETDIV = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t        state_r;
  ttbc_in_t      item_r;
  ttbc_out_t     out_data_r;
  logic          out_valid_r;
  logic [7:0]    min_tempo_r;
  logic [2:0]    min_intv_r;
  logic [15:0]   tempo_q4_r;
  logic [31:0]   interval_r;
  logic [31:0]   last_beat_r;
  logic          phase_r;
  logic          event_r;

  ttbc_tap_ctl_t    tap_ctl;
  ttbc_tap_sts_t    tap_sts;
  logic [SUM_W-1:0] tap_sum;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend, div_divisor, div_quo;
  ttbc_div_sts_t    div_sts;

  logic              in_fire, cfg_wr, tempo_on;
  logic [8:0]        set_t;
  logic [N_W-1:0]    n_int;
  logic              enough;
  logic [DIV_W-1:0]  mean_ms;
  logic [DIV_W+9:0]  mean_us;
  logic [16:0]       round_sum;
  logic [12:0]       round_raw;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign tempo_on = tempo_q4_r > {4'b0, min_tempo_r, 4'b0};
  assign set_t    = {1'b0, min_tempo_r} + {2'b0, item_r.cc_value};
  assign n_int    = N_W'(tap_sts.fill - 1'b1);
  assign enough   = (n_int != '0) && ({3'b0, n_int} >= {{N_W{1'b0}}, min_intv_r});
  assign mean_ms  = div_quo;
  assign mean_us  = mean_ms * US_PER_MS;

  // Register read
  always_comb begin
    unique case (paddr[2])
      REG_MIN_TEMPO: prdata = {24'b0, min_tempo_r};
      REG_MIN_INTV:  prdata = {29'b0, min_intv_r};
      default:       prdata = '0;
    endcase
  end

  // Drive tap window and divider
  always_comb begin
    tap_ctl.purge     = (state_r == S_STEP) &&
                        ((item_r.mode == MODE_UPDATE) || (item_r.mode == MODE_TAP));
    tap_ctl.push      = (state_r == S_PUSH);
    tap_ctl.sum_start = (state_r == S_PUSH);
    div_start         = 1'b0;
    div_dividend      = '0;
    div_divisor       = '0;
    if (state_r == S_STEP && item_r.mode == MODE_SET && set_t != '0) begin
      div_start    = 1'b1;
      div_dividend = DIV_W'(US_PER_MIN) + DIV_W'(set_t >> 1);
      div_divisor  = DIV_W'(set_t);
    end else if (state_r == S_CHK && enough) begin
      div_start    = 1'b1;
      div_dividend = tap_sum;
      div_divisor  = DIV_W'(n_int) * DIV_W'(US_PER_MS);
    end else if (state_r == S_DIV1 && div_sts.done && mean_ms != '0) begin
      div_start    = 1'b1;
      div_dividend = DIV_W'(TEMPO_NUM_Q4) + (mean_ms >> 1);
      div_divisor  = mean_ms;
    end
  end

  // Result fields from state
  assign round_sum = {1'b0, tempo_q4_r} + 17'd8;
  assign round_raw = round_sum[16:4];

  // Sequence one item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_tempo_r <= RST_MIN_TEMPO;
      min_intv_r  <= RST_MIN_INTV;
      tempo_q4_r  <= {4'b0, RST_MIN_TEMPO, 4'b0};
      interval_r  <= '0;
      last_beat_r <= '0;
      phase_r     <= 1'b0;
      event_r     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_MIN_TEMPO: min_tempo_r <= pwdata[7:0];
          REG_MIN_INTV:  min_intv_r  <= pwdata[2:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            item_r  <= in_data;
            event_r <= 1'b0;
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          state_r <= S_DONE;
          if (item_r.mode == MODE_UPDATE || item_r.mode == MODE_TAP) begin
            if (tempo_on && ((item_r.time_us - last_beat_r) > interval_r)) begin
              phase_r     <= ~phase_r;
              last_beat_r <= last_beat_r + interval_r;
              event_r     <= 1'b1;
            end
            if (item_r.mode == MODE_TAP) state_r <= S_PUSH;
          end else if (item_r.mode == MODE_SET) begin
            tempo_q4_r <= {3'b0, set_t, 4'b0};
            if (set_t == '0) interval_r <= '1;
            else state_r <= S_SETDIV;
          end
        end
        S_PUSH: state_r <= S_SUM;
        S_SUM: if (tap_sts.sum_done) state_r <= S_CHK;
        S_CHK: state_r <= enough ? S_DIV1 : S_DONE;
        S_DIV1: begin
          if (div_sts.done) begin
            if (mean_ms == '0) begin
              tempo_q4_r <= 16'hFFFF;
              interval_r <= '0;
              state_r    <= S_DONE;
            end else begin
              interval_r <= mean_us[31:0];
              state_r    <= S_DIV2;
            end
          end
        end
        S_DIV2: begin
          if (div_sts.done) begin
            tempo_q4_r <= (|div_quo[DIV_W-1:16]) ? 16'hFFFF : div_quo[15:0];
            state_r    <= S_DONE;
          end
        end
        S_SETDIV: begin
          if (div_sts.done) begin
            interval_r <= div_quo[31:0];
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r                    <= 1'b1;
            out_data_r.beat_symbol         <= tempo_on ? (phase_r ? SYM_DOWN : SYM_UP)
                                                       : SYM_OFF;
            out_data_r.beat_event          <= event_r;
            out_data_r.tempo_rounded       <= round_raw[12] ? 12'hFFF : round_raw[11:0];
            out_data_r.beat_interval_us    <= interval_r;
            out_data_r.taps_held           <= 4'(tap_sts.fill);
            out_data_r.controller_readback <= tempo_q4_r[11:4] - min_tempo_r;
            state_r                        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ttbc_taps u_taps (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tap_ctl),
    .now   (item_r.time_us),
    .sum   (tap_sum),
    .sts   (tap_sts)
  );

  ttbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .sts      (div_sts)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tap_sts.fill <= FILL_W'(TAP_DEPTH)) else $error("tap fill over depth");
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy) else $error("divider restarted while busy");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_STEP) else $error("accepted item not started");
  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV1 || state_r == S_DIV2 || state_r == S_SETDIV))
    else $error("divider result with no consumer");
`endif

endmodule
